### rtl/csmaca_pkg.sv
// ----------------------------------------------------------------------------
// csmaca_pkg
// Types and constants shared by the CSMA-CA ack retry controller files.
// ----------------------------------------------------------------------------
package csmaca_pkg;

   typedef enum logic [2:0] {
      ACT_SEND_REQUEST   = 3'd0,
      ACT_BACKOFF_EXPIRE = 3'd1,
      ACT_CCA_BUSY       = 3'd2,
      ACT_TX_READY       = 3'd3,
      ACT_TX_END         = 3'd4,
      ACT_FRAME_OK       = 3'd5,
      ACT_CRC_ERROR      = 3'd6,
      ACT_ACK_TIMEOUT    = 3'd7
   } action_type;

   typedef enum logic [2:0] {
      CMD_NONE     = 3'd0,
      CMD_BACKOFF  = 3'd1,
      CMD_CCA      = 3'd2,
      CMD_TX       = 3'd3,
      CMD_ACK_WAIT = 3'd4,
      CMD_FINISH   = 3'd5
   } command_type;

   typedef enum logic [1:0] {
      FS_SUCCESS = 2'd0,
      FS_BUSY    = 2'd1,
      FS_NO_ACK  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE      = 2'd0,
      ST_SENT      = 2'd1,
      ST_SENT_ACK  = 2'd2,
      ST_AWAIT_ACK = 2'd3
   } send_state_type;

   typedef enum logic [2:0] {
      CSR_MIN_BE       = 3'd0,
      CSR_MAX_BE       = 3'd1,
      CSR_MAX_BACKOFFS = 3'd2,
      CSR_MAX_ACK_ATT  = 3'd3,
      CSR_UNIT_BACKOFF = 3'd4,
      CSR_SHORT_IFS    = 3'd5,
      CSR_LONG_IFS     = 3'd6,
      CSR_ACK_WAIT     = 3'd7
   } csr_index_type;

   typedef struct packed {
      action_type  action;
      logic        ack_requested;
      logic [7:0]  random_value;
      logic        radio_receiving;
      logic [31:0] elapsed_us;
      logic        ack_override;
      logic [6:0]  frame_length;
      logic        is_matching_ack;
   } req_item_type;

   typedef struct packed {
      command_type command;
      logic [19:0] delay_us;
      status_type  finish_status;
   } rsp_item_type;

   localparam logic [6:0]  SHORT_FRAME_MAX = 7'd18;

   localparam logic [3:0]  RST_MIN_BE       = 4'd3;
   localparam logic [3:0]  RST_MAX_BE       = 4'd5;
   localparam logic [3:0]  RST_MAX_BACKOFFS = 4'd3;
   localparam logic [3:0]  RST_MAX_ACK_ATT  = 4'd3;
   localparam logic [11:0] RST_UNIT_BACKOFF = 12'd320;
   localparam logic [15:0] RST_SHORT_IFS    = 16'd192;
   localparam logic [15:0] RST_LONG_IFS     = 16'd640;
   localparam logic [15:0] RST_ACK_WAIT     = 16'd864;

endpackage

### rtl/csmaca_if.sv
// ----------------------------------------------------------------------------
// csmaca channel interfaces
// Valid/ready channels for events, commands and register writes.
// ----------------------------------------------------------------------------
interface csmaca_req_if;
   import csmaca_pkg::*;
   logic        valid;
   logic        ready;
   action_type  action;
   logic        ack_requested;
   logic [7:0]  random_value;
   logic        radio_receiving;
   logic [31:0] elapsed_us;
   logic        ack_override;
   logic [6:0]  frame_length;
   logic        is_matching_ack;

   modport source (output valid, action, ack_requested, random_value, radio_receiving,
                   elapsed_us, ack_override, frame_length, is_matching_ack,
                   input ready);
   modport sink   (input valid, action, ack_requested, random_value, radio_receiving,
                   elapsed_us, ack_override, frame_length, is_matching_ack,
                   output ready);
endinterface

interface csmaca_rsp_if;
   import csmaca_pkg::*;
   logic        valid;
   logic        ready;
   command_type command;
   logic [19:0] delay_us;
   status_type  finish_status;

   modport source (output valid, command, delay_us, finish_status, input ready);
   modport sink   (input valid, command, delay_us, finish_status, output ready);
endinterface

interface csmaca_csr_if;
   import csmaca_pkg::*;
   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [15:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### rtl/csma_ca_ack_retry_control.sv
// ----------------------------------------------------------------------------
// csma_ca_ack_retry_control
// Unslotted CSMA-CA transmit controller with acknowledgement retries.
// ----------------------------------------------------------------------------
// Usage:
//  req_chan carries radio and timer events; every event yields exactly one
//  command item on rsp_chan (arm backoff, start CCA, start transmit, arm ack
//  wait, finish, or none). csr_chan writes the eight setup registers; it is
//  always ready. The user must write it only while no event is in flight;
//  the block itself does not enforce this. The event register loads at
//  acceptance and the command register loads from it when rsp_chan can take
//  a command. One event per cycle is sustained while rsp_chan is ready; the backoff
//  delay multiply (9 x 12 bits) and the 32-bit spacing compare sit between them.
//  Reset (synchronous, active high) returns the send state to idle, clears
//  the backoff and ack counters, assumes long spacing and loads the default
//  register values.
//  When rsp_chan stalls, the command register holds; the event register still
//  takes one more event only if it is empty, after which req_chan.ready drops.
// ----------------------------------------------------------------------------
module csma_ca_ack_retry_control (
   input logic                 clock,
   input logic                 reset,
   csmaca_req_if.sink          req_chan,
   csmaca_rsp_if.source        rsp_chan,
   csmaca_csr_if.sink          csr_chan
);
   import csmaca_pkg::*;

   // setup registers
   logic [3:0]  min_be_ff, max_be_ff, max_backoffs_ff, max_ack_att_ff;
   logic [11:0] unit_backoff_ff;
   logic [15:0] short_ifs_ff, long_ifs_ff, ack_wait_ff;

   // control state
   send_state_type state_ff, state_in;
   logic [3:0]     be_ff, be_in, cnt_ff, cnt_in, att_ff, att_in;
   logic           ls_ff, ls_in;

   // pipeline
   logic           s1_valid_ff, rsp_valid_ff, advance;
   req_item_type   item_ff;
   rsp_item_type   rsp_ff, rsp_in;

   // backoff draw
   logic           do_draw, fresh;
   logic [3:0]     be_src, cnt_src;
   logic [7:0]     rnd_mask;
   logic [8:0]     slots;
   logic [20:0]    draw_delay;
   logic [15:0]    ifs_us;

   assign advance        = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.command       = rsp_ff.command;
   assign rsp_chan.delay_us      = rsp_ff.delay_us;
   assign rsp_chan.finish_status = rsp_ff.finish_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_be_ff       <= RST_MIN_BE;
         max_be_ff       <= RST_MAX_BE;
         max_backoffs_ff <= RST_MAX_BACKOFFS;
         max_ack_att_ff  <= RST_MAX_ACK_ATT;
         unit_backoff_ff <= RST_UNIT_BACKOFF;
         short_ifs_ff    <= RST_SHORT_IFS;
         long_ifs_ff     <= RST_LONG_IFS;
         ack_wait_ff     <= RST_ACK_WAIT;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_MIN_BE:       min_be_ff       <= csr_chan.data[3:0];
            CSR_MAX_BE:       max_be_ff       <= csr_chan.data[3:0];
            CSR_MAX_BACKOFFS: max_backoffs_ff <= csr_chan.data[3:0];
            CSR_MAX_ACK_ATT:  max_ack_att_ff  <= csr_chan.data[3:0];
            CSR_UNIT_BACKOFF: unit_backoff_ff <= csr_chan.data[11:0];
            CSR_SHORT_IFS:    short_ifs_ff    <= csr_chan.data;
            CSR_LONG_IFS:     long_ifs_ff     <= csr_chan.data;
            CSR_ACK_WAIT:     ack_wait_ff     <= csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_IDLE;
         be_ff        <= '0;
         cnt_ff       <= '0;
         att_ff       <= '0;
         ls_ff        <= 1'b1;
      end else begin
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
            be_ff        <= be_in;
            cnt_ff       <= cnt_in;
            att_ff       <= att_in;
            ls_ff        <= ls_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         item_ff.action          <= req_chan.action;
         item_ff.ack_requested   <= req_chan.ack_requested;
         item_ff.random_value    <= req_chan.random_value;
         item_ff.radio_receiving <= req_chan.radio_receiving;
         item_ff.elapsed_us      <= req_chan.elapsed_us;
         item_ff.ack_override    <= req_chan.ack_override;
         item_ff.frame_length    <= req_chan.frame_length;
         item_ff.is_matching_ack <= req_chan.is_matching_ack;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // a new access attempt restarts exponent and count
   assign fresh      = (item_ff.action == ACT_SEND_REQUEST) ||
                       (item_ff.action == ACT_ACK_TIMEOUT);
   assign be_src     = fresh ? min_be_ff : be_ff;
   assign cnt_src    = fresh ? 4'd0 : cnt_ff;
   assign rnd_mask   = (be_src >= 4'd8) ? 8'hFF : ~(8'hFF << be_src[2:0]);
   assign slots      = {1'b0, item_ff.random_value & rnd_mask} + 9'd1;
   assign draw_delay = slots * unit_backoff_ff;
   assign ifs_us     = ls_ff ? long_ifs_ff : short_ifs_ff;

   always_comb begin
      state_in = state_ff;
      be_in    = be_ff;
      cnt_in   = cnt_ff;
      att_in   = att_ff;
      ls_in    = ls_ff;
      rsp_in   = '{command: CMD_NONE, delay_us: '0, finish_status: FS_SUCCESS};
      do_draw  = 1'b0;

      case (item_ff.action)
         ACT_SEND_REQUEST: begin
            if (state_ff == ST_IDLE) begin
               state_in = item_ff.ack_requested ? ST_SENT_ACK : ST_SENT;
               att_in   = 4'd1;
               be_in    = min_be_ff;
               cnt_in   = 4'd0;
               do_draw  = 1'b1;
            end
         end
         ACT_BACKOFF_EXPIRE: begin
            if (state_ff != ST_IDLE) begin
               if (item_ff.radio_receiving && item_ff.elapsed_us >= {16'd0, ifs_us}) begin
                  rsp_in.command = CMD_CCA;
               end else begin
                  do_draw = 1'b1;
               end
            end
         end
         ACT_CCA_BUSY: begin
            if (state_ff != ST_IDLE) begin
               do_draw = 1'b1;
            end
         end
         ACT_TX_READY: begin
            if (state_ff != ST_IDLE) begin
               if (item_ff.ack_override) begin
                  do_draw = 1'b1;
               end else begin
                  ls_in          = item_ff.frame_length > SHORT_FRAME_MAX;
                  rsp_in.command = CMD_TX;
               end
            end
         end
         ACT_TX_END: begin
            if (state_ff == ST_SENT_ACK) begin
               state_in        = ST_AWAIT_ACK;
               rsp_in.command  = CMD_ACK_WAIT;
               rsp_in.delay_us = {4'd0, ack_wait_ff};
            end else if (state_ff == ST_SENT) begin
               state_in       = ST_IDLE;
               rsp_in.command = CMD_FINISH;
            end
         end
         ACT_FRAME_OK: begin
            ls_in = item_ff.frame_length > SHORT_FRAME_MAX;
            if (state_ff == ST_AWAIT_ACK && item_ff.is_matching_ack) begin
               state_in       = ST_IDLE;
               rsp_in.command = CMD_FINISH;
            end
         end
         ACT_CRC_ERROR: begin
            ls_in = 1'b1;
         end
         ACT_ACK_TIMEOUT: begin
            if (state_ff == ST_AWAIT_ACK) begin
               if (att_ff < max_ack_att_ff) begin
                  state_in = ST_SENT_ACK;
                  att_in   = att_ff + 4'd1;
                  be_in    = min_be_ff;
                  cnt_in   = 4'd0;
                  do_draw  = 1'b1;
               end else begin
                  state_in             = ST_IDLE;
                  rsp_in.command       = CMD_FINISH;
                  rsp_in.finish_status = FS_NO_ACK;
               end
            end
         end
         default: ;
      endcase

      if (do_draw) begin
         if (cnt_src >= max_backoffs_ff) begin
            state_in             = ST_IDLE;
            rsp_in.command       = CMD_FINISH;
            rsp_in.finish_status = FS_BUSY;
         end else begin
            rsp_in.command  = CMD_BACKOFF;
            rsp_in.delay_us = draw_delay[19:0];
            be_in  = ({1'b0, be_src} + 5'd1 < {1'b0, max_be_ff}) ? be_src + 4'd1 : max_be_ff;
            cnt_in = cnt_src + 4'd1;
         end
      end
   end

   // finishing always leaves the controller idle
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.command == CMD_FINISH |=> state_ff == ST_IDLE)
      else $error("finish did not return to idle");

   // a send in progress has counted at least one transmission
   a_attempts: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> att_ff != 4'd0)
      else $error("active send with zero ack attempts");

   // delay only accompanies timer commands
   a_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.command != CMD_BACKOFF && rsp_ff.command != CMD_ACK_WAIT
      |-> rsp_ff.delay_us == 20'd0)
      else $error("delay on non-timer command");

   // status only accompanies finish
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.command != CMD_FINISH |-> rsp_ff.finish_status == FS_SUCCESS)
      else $error("status on non-finish command");

endmodule
